[rtl/pidhc_pkg.sv]
// pidhc_pkg: shared widths, constants and codes for the heat/cool pid drive
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package pidhc_pkg;

	// field widths
	localparam int TEMP_W     = 16;
	localparam int SETPOINT_W = 14;
	localparam int GAIN_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int ERR_W      = 18;
	localparam int INTEG_W    = 16;
	localparam int DERIV_W    = 22;
	localparam int ACC_W      = 49;
	localparam int OUT_W      = 16;
	localparam int MAG_W      = 15;
	localparam int DUTY_W     = 10;

	// register reset values and limits
	localparam logic [SETPOINT_W-1:0] SETPOINT_RESET = SETPOINT_W'(6400);
	localparam logic [SETPOINT_W-1:0] SETPOINT_LOW   = SETPOINT_W'(1280);
	localparam logic [SETPOINT_W-1:0] SETPOINT_HIGH  = SETPOINT_W'(11520);
	localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = GAIN_W'(1966080);
	localparam logic signed [GAIN_W-1:0] GAIN_I_RESET = GAIN_W'(5243);
	localparam logic signed [GAIN_W-1:0] GAIN_D_RESET = GAIN_W'(131072);

	localparam int INTEG_LIMIT = 25600;
	localparam int OUT_LIMIT   = 25600;
	localparam int ROUND_BIAS  = 32768;
	localparam int FRAC_BITS   = 16;

	// x/5 as (x*52429)>>18, exact below 2^18
	localparam logic [15:0] DIV5_MUL   = 16'd52429;
	localparam int          DIV5_SHIFT = 18;

	// x/25600 as ((x>>10)*ceil(2^30/25))>>30
	localparam int          SCALE_SHIFT = 10;
	localparam logic [25:0] DIV25_MUL   = 26'd42949673;
	localparam int          DIV25_SHIFT = 30;
	localparam int          DIV25_MUL_W = 26;

	localparam int DUTY_MAX          = 1023;
	localparam int PWM_STEPS_DEFAULT = 1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT = 2'd0,
		REG_GAIN_P   = 2'd1,
		REG_GAIN_I   = 2'd2,
		REG_GAIN_D   = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_HEAT = 2'd1,
		MODE_COOL = 2'd2
	} drive_mode_t;

	// load strobes for each pipeline stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

endpackage

[rtl/pidhc_front.sv]
// pidhc_front: configuration registers, error, clamped integral and derivative
// depends on pidhc_pkg; feeds pidhc_mac
`timescale 1ns / 1ps

module pidhc_front import pidhc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [GAIN_W-1:0]           cfg_data,
	input  pipe_en_t                    en,
	input  logic signed [TEMP_W-1:0]    measured_temp,
	output logic signed [ERR_W-1:0]     err_s1,
	output logic signed [INTEG_W-1:0]   integ_s1,
	output logic signed [DERIV_W-1:0]   deriv_s1,
	output logic signed [GAIN_W-1:0]    gain_p_q,
	output logic signed [GAIN_W-1:0]    gain_i_q,
	output logic signed [GAIN_W-1:0]    gain_d_q
);

	logic [SETPOINT_W-1:0]      setpoint_q;
	logic signed [INTEG_W-1:0]  integral_q;
	logic signed [ERR_W-1:0]    last_error_q;

	logic signed [ERR_W-1:0]    err;
	logic [ERR_W-2:0]           mag_e;
	logic [ERR_W-2:0]           mag_r;
	logic [32:0]                div_prod;
	logic [14:0]                inc_mag;
	logic signed [INTEG_W:0]    inc_s;
	logic signed [INTEG_W:0]    integ_raw;
	logic signed [INTEG_W-1:0]  integ;
	logic signed [ERR_W:0]      diff;
	logic signed [DERIV_W-1:0]  diff_x;
	logic signed [DERIV_W-1:0]  deriv;
	logic [SETPOINT_W-1:0]      sp_new;

	assign sp_new = cfg_data[SETPOINT_W-1:0];

	always_comb begin
		err = $signed(ERR_W'(setpoint_q)) - ERR_W'(measured_temp);
		mag_e = err[ERR_W-1] ? (ERR_W-1)'(-err) : (ERR_W-1)'(err);
		// increment is e/5 rounded, symmetric about zero
		mag_r = mag_e + (ERR_W-1)'(2);
		div_prod = 33'(mag_r) * 33'(DIV5_MUL);
		inc_mag = 15'(div_prod >> DIV5_SHIFT);
		inc_s = err[ERR_W-1] ? -$signed({2'b00, inc_mag}) : $signed({2'b00, inc_mag});
		integ_raw = (INTEG_W+1)'(integral_q) + inc_s;
		if (integ_raw > INTEG_LIMIT) begin
			integ = INTEG_W'(INTEG_LIMIT);
		end else if (integ_raw < -INTEG_LIMIT) begin
			integ = INTEG_W'(-INTEG_LIMIT);
		end else begin
			integ = INTEG_W'(integ_raw);
		end
		diff = (ERR_W+1)'(err) - (ERR_W+1)'(last_error_q);
		diff_x = DERIV_W'(diff);
		deriv = (diff_x <<< 2) + diff_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= SETPOINT_RESET;
			gain_p_q     <= GAIN_P_RESET;
			gain_i_q     <= GAIN_I_RESET;
			gain_d_q     <= GAIN_D_RESET;
			integral_q   <= '0;
			last_error_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_SETPOINT: begin
					if (sp_new inside {[SETPOINT_LOW:SETPOINT_HIGH]}) begin
						setpoint_q   <= sp_new;
						integral_q   <= '0;
						last_error_q <= '0;
					end
				end
				REG_GAIN_P: begin
					gain_p_q     <= cfg_data;
					integral_q   <= '0;
					last_error_q <= '0;
				end
				REG_GAIN_I: begin
					gain_i_q     <= cfg_data;
					integral_q   <= '0;
					last_error_q <= '0;
				end
				REG_GAIN_D: begin
					gain_d_q     <= cfg_data;
					integral_q   <= '0;
					last_error_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (en.s1) begin
			integral_q   <= integ;
			last_error_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			err_s1   <= err;
			integ_s1 <= integ;
			deriv_s1 <= deriv;
		end
	end

endmodule

[rtl/pidhc_mac.sv]
// pidhc_mac: three gain products, rounded sum and output saturation
// depends on pidhc_pkg; fed by pidhc_front, feeds pidhc_duty
`timescale 1ns / 1ps

module pidhc_mac import pidhc_pkg::*; (
	input  logic                        clk,
	input  pipe_en_t                    en,
	input  logic signed [ERR_W-1:0]     err_s1,
	input  logic signed [INTEG_W-1:0]   integ_s1,
	input  logic signed [DERIV_W-1:0]   deriv_s1,
	input  logic signed [GAIN_W-1:0]    gain_p,
	input  logic signed [GAIN_W-1:0]    gain_i,
	input  logic signed [GAIN_W-1:0]    gain_d,
	output logic signed [OUT_W-1:0]     u_s3,
	output logic [MAG_W-1:0]            mag_s3
);

	localparam int PP_W = GAIN_W + ERR_W;
	localparam int PI_W = GAIN_W + INTEG_W;
	localparam int PD_W = GAIN_W + DERIV_W;

	logic signed [PP_W-1:0]   prod_p_s2;
	logic signed [PI_W-1:0]   prod_i_s2;
	logic signed [PD_W-1:0]   prod_d_s2;

	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  shifted;
	logic signed [OUT_W-1:0]  u_sat;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_p_s2 <= gain_p * err_s1;
			prod_i_s2 <= gain_i * integ_s1;
			prod_d_s2 <= gain_d * deriv_s1;
		end
	end

	always_comb begin
		acc = ACC_W'(prod_p_s2) + ACC_W'(prod_i_s2) + ACC_W'(prod_d_s2)
			+ ACC_W'(ROUND_BIAS);
		shifted = acc >>> FRAC_BITS;
		if (shifted > OUT_LIMIT) begin
			u_sat = OUT_W'(OUT_LIMIT);
		end else if (shifted < -OUT_LIMIT) begin
			u_sat = OUT_W'(-OUT_LIMIT);
		end else begin
			u_sat = OUT_W'(shifted);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			u_s3   <= u_sat;
			mag_s3 <= u_sat[OUT_W-1] ? MAG_W'(-u_sat) : MAG_W'(u_sat);
		end
	end

endmodule

[rtl/pidhc_duty.sv]
// pidhc_duty: pwm compare value from |u|, drive mode and the output register
// depends on pidhc_pkg; fed by pidhc_mac
`timescale 1ns / 1ps

module pidhc_duty import pidhc_pkg::*; #(
	parameter int PWM_STEPS = PWM_STEPS_DEFAULT
) (
	input  logic                        clk,
	input  pipe_en_t                    en,
	input  logic signed [OUT_W-1:0]     u_s3,
	input  logic [MAG_W-1:0]            mag_s3,
	output logic signed [OUT_W-1:0]     control_value,
	output logic [DUTY_W-1:0]           pwm_duty,
	output logic [1:0]                  drive_mode
);

	localparam int SW  = (PWM_STEPS > 2) ? $clog2(PWM_STEPS) : 1;
	localparam int PW  = MAG_W + SW;
	localparam int QW  = PW - SCALE_SHIFT;
	localparam int RPW = QW + DIV25_MUL_W;
	localparam int RW  = RPW - DIV25_SHIFT;
	localparam int WW  = (RW > DUTY_W) ? RW : DUTY_W + 1;
	localparam logic [SW-1:0] STEP_MAX = SW'(PWM_STEPS - 1);

	logic [PW-1:0]             prod_s4;
	logic signed [OUT_W-1:0]   u_s4;

	logic [RPW-1:0]            recip_prod;
	logic [WW-1:0]             duty_full;
	logic [DUTY_W-1:0]         duty;
	drive_mode_t               mode;

	logic signed [OUT_W-1:0]   ctrl_s5;
	logic [DUTY_W-1:0]         duty_s5;
	drive_mode_t               mode_s5;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			prod_s4 <= PW'(mag_s3) * PW'(STEP_MAX);
			u_s4    <= u_s3;
		end
	end

	always_comb begin
		// divide by 25600: drop 10 bits, then multiply by the reciprocal of 25
		recip_prod = RPW'(prod_s4[PW-1:SCALE_SHIFT]) * RPW'(DIV25_MUL);
		duty_full = WW'(recip_prod[RPW-1:DIV25_SHIFT]);
		if (duty_full > WW'(DUTY_MAX)) begin
			duty = DUTY_W'(DUTY_MAX);
		end else begin
			duty = duty_full[DUTY_W-1:0];
		end
		if (duty == '0) begin
			mode = MODE_OFF;
		end else if (u_s4 > 0) begin
			mode = MODE_HEAT;
		end else begin
			mode = MODE_COOL;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			ctrl_s5 <= u_s4;
			duty_s5 <= duty;
			mode_s5 <= mode;
		end
	end

	assign control_value = ctrl_s5;
	assign pwm_duty      = duty_s5;
	assign drive_mode    = mode_s5;

endmodule

[rtl/pid_heat_cool_drive_unit.sv]
// pid_heat_cool_drive_unit: top level, pipeline valid/ready control and assertions
// depends on pidhc_pkg, pidhc_front, pidhc_mac, pidhc_duty
//
// channel   direction  handshake           word
// in        sink       in_valid/in_ready   measured_temp
// out       source     out_valid/out_ready control_value, pwm_duty, drive_mode
// cfg       sink       cfg_wr_en           cfg_index, cfg_data
//
// one word per cycle sustained while out_ready is high; out_valid rises when the word reaches stage s5
// integral and last error update in stage 1 at accept, so words follow back to back
// stages s1..s5 each hold when full and the stage after them cannot take a word
// out_ready low holds the output register; earlier empty stages keep filling
// arst_n clears valids, config registers to their defaults and the pid state
`timescale 1ns / 1ps

module pid_heat_cool_drive_unit import pidhc_pkg::*; #(
	parameter int PWM_STEPS = PWM_STEPS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [GAIN_W-1:0]           cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [TEMP_W-1:0]    measured_temp,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [OUT_W-1:0]     control_value,
	output logic [DUTY_W-1:0]           pwm_duty,
	output logic [1:0]                  drive_mode
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy2, rdy3, rdy4, rdy5;
	pipe_en_t en;

	logic signed [ERR_W-1:0]    err_s1;
	logic signed [INTEG_W-1:0]  integ_s1;
	logic signed [DERIV_W-1:0]  deriv_s1;
	logic signed [GAIN_W-1:0]   gain_p_q, gain_i_q, gain_d_q;
	logic signed [OUT_W-1:0]    u_s3;
	logic [MAG_W-1:0]           mag_s3;

	always_comb begin
		rdy5     = !valid_s5 || out_ready;
		rdy4     = !valid_s4 || rdy5;
		rdy3     = !valid_s3 || rdy4;
		rdy2     = !valid_s2 || rdy3;
		in_ready = !valid_s1 || rdy2;
		en.s1 = in_valid && in_ready;
		en.s2 = valid_s1 && rdy2;
		en.s3 = valid_s2 && rdy3;
		en.s4 = valid_s3 && rdy4;
		en.s5 = valid_s4 && rdy5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (rdy2)     valid_s2 <= valid_s1;
			if (rdy3)     valid_s3 <= valid_s2;
			if (rdy4)     valid_s4 <= valid_s3;
			if (rdy5)     valid_s5 <= valid_s4;
		end
	end

	assign out_valid = valid_s5;

	pidhc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.en            (en),
		.measured_temp (measured_temp),
		.err_s1        (err_s1),
		.integ_s1      (integ_s1),
		.deriv_s1      (deriv_s1),
		.gain_p_q      (gain_p_q),
		.gain_i_q      (gain_i_q),
		.gain_d_q      (gain_d_q)
	);

	pidhc_mac u_mac (
		.clk      (clk),
		.en       (en),
		.err_s1   (err_s1),
		.integ_s1 (integ_s1),
		.deriv_s1 (deriv_s1),
		.gain_p   (gain_p_q),
		.gain_i   (gain_i_q),
		.gain_d   (gain_d_q),
		.u_s3     (u_s3),
		.mag_s3   (mag_s3)
	);

	pidhc_duty #(
		.PWM_STEPS (PWM_STEPS)
	) u_duty (
		.clk           (clk),
		.en            (en),
		.u_s3          (u_s3),
		.mag_s3        (mag_s3),
		.control_value (control_value),
		.pwm_duty      (pwm_duty),
		.drive_mode    (drive_mode)
	);

	// an accepted word always lands in stage 1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		en.s1 |=> valid_s1)
		else $error("accepted word missing from stage 1");

	// a new result only appears when stage 4 held a word
	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s4))
		else $error("result appeared without a word in stage 4");

	a_zero_duty_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pwm_duty == '0) |-> (drive_mode == MODE_OFF))
		else $error("zero duty with drive not off");

	a_heat_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drive_mode == MODE_HEAT) |-> (control_value > 0))
		else $error("heat mode with non-positive control value");

	a_out_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (control_value <= OUT_LIMIT && control_value >= -OUT_LIMIT))
		else $error("control value outside saturation limits");

endmodule

[bench/pid_heat_cool_drive_unit_tb.sv]
// pid_heat_cool_drive_unit_tb: self-checking bench for the heat/cool pid drive unit
// directed rows then randomized phases, every drive word checked against a typed row or a local pid model
// depends on pidhc_pkg and pid_heat_cool_drive_unit
`timescale 1ns / 1ps

module pid_heat_cool_drive_unit_tb;
	import pidhc_pkg::*;

	parameter int PWM_STEPS = PWM_STEPS_DEFAULT;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int PHASES          = 16;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int DRAIN_CYCLES    = 8;

	typedef struct packed {
		logic signed [OUT_W-1:0] control_value;
		logic [DUTY_W-1:0]       pwm_duty;
		drive_mode_t             drive_mode;
	} drive_word_t;

	typedef struct {
		bit                       is_write;
		cfg_reg_t                 reg_sel;
		logic [GAIN_W-1:0]        data;
		logic signed [TEMP_W-1:0] temp;
		bit                       typed;
		drive_word_t              word;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	cfg_reg_t                 cfg_index = REG_SETPOINT;
	logic [GAIN_W-1:0]        cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [TEMP_W-1:0] measured_temp = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b1;
	logic signed [OUT_W-1:0]  control_value;
	logic [DUTY_W-1:0]        pwm_duty;
	logic [1:0]               drive_mode;

	// hand-typed expectation travelling with the current word
	bit          row_typed = 1'b0;
	drive_word_t row_word = '0;

	// local copy of registers and pid state
	logic [SETPOINT_W-1:0]    sp_reg = SETPOINT_RESET;
	logic signed [GAIN_W-1:0] kp_reg = GAIN_P_RESET;
	logic signed [GAIN_W-1:0] ki_reg = GAIN_I_RESET;
	logic signed [GAIN_W-1:0] kd_reg = GAIN_D_RESET;
	int                       integ_acc = 0;
	int                       prev_err = 0;

	drive_word_t expected_drive[$];
	stim_row_t   directed_rows[$];
	int          words_sent = 0;
	int          results_seen = 0;
	int          writes_done = 0;
	int          fails = 0;
	int          cycles = 0;
	bit          calm = 1'b0;

	pid_heat_cool_drive_unit #(
		.PWM_STEPS(PWM_STEPS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.measured_temp(measured_temp),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.control_value(control_value),
		.pwm_duty     (pwm_duty),
		.drive_mode   (drive_mode)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("pid_heat_cool_drive_unit_tb failed");
			$finish;
		end
	end

	function automatic void clear_pid_state();
		integ_acc = 0;
		prev_err  = 0;
	endfunction

	function automatic void apply_write(cfg_reg_t r, logic [GAIN_W-1:0] d);
		case (r)
			REG_SETPOINT: begin
				// out-of-range setpoints leave register and state alone
				if (d[SETPOINT_W-1:0] >= SETPOINT_LOW && d[SETPOINT_W-1:0] <= SETPOINT_HIGH) begin
					sp_reg = d[SETPOINT_W-1:0];
					clear_pid_state();
				end
			end
			REG_GAIN_P: begin
				kp_reg = d;
				clear_pid_state();
			end
			REG_GAIN_I: begin
				ki_reg = d;
				clear_pid_state();
			end
			REG_GAIN_D: begin
				kd_reg = d;
				clear_pid_state();
			end
			default: ;
		endcase
	endfunction

	function automatic drive_word_t predict_drive(logic signed [TEMP_W-1:0] temp);
		int          err, mag_e, step_i, integ;
		longint      deriv, acc, u, mag_u, duty;
		drive_word_t w;
		err   = int'(sp_reg) - int'(temp);
		mag_e = (err < 0) ? -err : err;
		// e/5 rounded to nearest, symmetric about zero
		step_i = (mag_e + 2) / 5;
		if (err < 0)
			step_i = -step_i;
		integ = integ_acc + step_i;
		if (integ > INTEG_LIMIT)
			integ = INTEG_LIMIT;
		if (integ < -INTEG_LIMIT)
			integ = -INTEG_LIMIT;
		integ_acc = integ;
		deriv    = (longint'(err) - longint'(prev_err)) * 5;
		prev_err = err;
		acc = longint'(kp_reg) * err + longint'(ki_reg) * integ + longint'(kd_reg) * deriv;
		// round half up, arithmetic shift floors
		u = (acc + ROUND_BIAS) >>> FRAC_BITS;
		if (u > OUT_LIMIT)
			u = OUT_LIMIT;
		if (u < -OUT_LIMIT)
			u = -OUT_LIMIT;
		mag_u = (u < 0) ? -u : u;
		duty  = mag_u * (PWM_STEPS - 1) / 25600;
		if (duty > DUTY_MAX)
			duty = DUTY_MAX;
		w.control_value = u[OUT_W-1:0];
		w.pwm_duty      = duty[DUTY_W-1:0];
		if (duty == 0)
			w.drive_mode = MODE_OFF;
		else if (u > 0)
			w.drive_mode = MODE_HEAT;
		else
			w.drive_mode = MODE_COOL;
		return w;
	endfunction

	always @(posedge clk) begin : scoreboard
		drive_word_t w;
		if (arst_n) begin
			if (cfg_wr_en)
				apply_write(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				w = predict_drive(measured_temp);
				expected_drive.push_back(row_typed ? row_word : w);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_drive.size() == 0) begin
					$error("drive word with nothing expected: cv %0d duty %0d mode %0d",
						control_value, pwm_duty, drive_mode);
					fails++;
				end else begin
					w = expected_drive.pop_front();
					if (control_value !== w.control_value) begin
						$error("control_value: expected %0d, got %0d", w.control_value,
							control_value);
						fails++;
					end
					if (pwm_duty !== w.pwm_duty) begin
						$error("pwm_duty: expected %0d, got %0d", w.pwm_duty, pwm_duty);
						fails++;
					end
					if (drive_mode !== w.drive_mode) begin
						$error("drive_mode: expected %0d, got %0d", w.drive_mode, drive_mode);
						fails++;
					end
				end
			end
		end
	end

	// sink side stalls in bursts, none in the last phase
	initial begin : sink_pacing
		int run;
		forever begin
			run = $urandom_range(1, 30);
			repeat (run) @(posedge clk);
			if (!calm && $urandom_range(0, 1) == 1) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	function automatic void add_write(cfg_reg_t r, logic [GAIN_W-1:0] d);
		stim_row_t row;
		row = '{1'b1, r, d, '0, 1'b0, '0};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_temp(int t);
		stim_row_t row;
		row = '{1'b0, REG_SETPOINT, '0, TEMP_W'(t), 1'b0, '0};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_typed(int t, int cv, int duty, drive_mode_t m);
		stim_row_t row;
		row = '{1'b0, REG_SETPOINT, '0, TEMP_W'(t), 1'b1, {OUT_W'(cv), DUTY_W'(duty), m}};
		directed_rows.push_back(row);
	endfunction

	task automatic send_word(logic signed [TEMP_W-1:0] t, bit typed, drive_word_t w);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		measured_temp <= t;
		row_typed     <= typed;
		row_word      <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// registers change only with the pipeline empty
	task automatic write_reg(cfg_reg_t r, logic [GAIN_W-1:0] d);
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_seen != words_sent)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		writes_done++;
	endtask

	function automatic logic [GAIN_W-1:0] random_gain();
		logic [GAIN_W-1:0] g;
		g = GAIN_W'($urandom_range(0, 1 << 19));
		case ($urandom_range(0, 15))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			3: return GAIN_W'($urandom);
			default: return ($urandom_range(0, 1) == 1) ? -g : g;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] random_setpoint();
		case ($urandom_range(0, 9))
			0: return GAIN_W'($urandom);
			1: return GAIN_W'(SETPOINT_LOW);
			2: return GAIN_W'(SETPOINT_HIGH);
			3: return {10'($urandom), 14'($urandom_range(1280, 11520))};
			default: return GAIN_W'($urandom_range(1280, 11520));
		endcase
	endfunction

	function automatic logic signed [TEMP_W-1:0] random_temp();
		int delta;
		case ($urandom_range(0, 19))
			0, 1, 2: return TEMP_W'($urandom);
			3, 4, 5, 6, 7: return TEMP_W'(int'($urandom_range(0, 42240)) - 10240);
			default: begin
				// mostly close to the target so the loop stays out of saturation
				delta = int'($urandom_range(0, 1024)) - 512;
				return TEMP_W'(int'(sp_reg) + delta);
			end
		endcase
	endfunction

	initial begin : stimulus
		stim_row_t row;
		// zero error after reset, then both rails
		add_typed(6400, 0, 0, MODE_OFF);
		add_typed(-32768, 25600, 999, MODE_HEAT);
		add_typed(32767, -25600, 999, MODE_COOL);
		add_temp(6400);
		// largest and smallest proportional gain on a one-lsb error
		add_write(REG_GAIN_I, 24'h000000);
		add_write(REG_GAIN_D, 24'h000000);
		add_write(REG_GAIN_P, 24'h7FFFFF);
		add_typed(6399, 128, 4, MODE_HEAT);
		add_typed(6401, -128, 4, MODE_COOL);
		add_write(REG_GAIN_P, 24'h800000);
		add_typed(6399, -128, 4, MODE_COOL);
		// half-lsb rounding, nonzero u with zero duty reads as off
		add_write(REG_GAIN_P, 24'd32768);
		add_typed(6399, 1, 0, MODE_OFF);
		add_typed(6401, 0, 0, MODE_OFF);
		// integral alone, runs into its clamp and comes back
		add_write(REG_GAIN_P, 24'h000000);
		add_write(REG_GAIN_I, 24'd65536);
		repeat (5) add_temp(-32768);
		add_temp(32767);
		// derivative alone
		add_write(REG_GAIN_I, 24'h000000);
		add_write(REG_GAIN_D, 24'd65536);
		add_temp(6400);
		add_temp(6144);
		add_temp(6656);
		// rejected setpoints keep the last error
		add_write(REG_SETPOINT, 24'd1279);
		add_write(REG_SETPOINT, 24'd11521);
		add_temp(6400);
		add_write(REG_SETPOINT, 24'd1280);
		add_temp(-10240);
		add_write(REG_SETPOINT, 24'd11520);
		add_temp(32000);
		// upper data bits are not part of the setpoint
		add_write(REG_SETPOINT, 24'hFFCBB8);
		add_write(REG_SETPOINT, 24'h003FFF);
		add_temp(3000);
		add_write(REG_GAIN_P, GAIN_P_RESET);
		add_write(REG_GAIN_I, GAIN_I_RESET);
		add_write(REG_GAIN_D, GAIN_D_RESET);
		add_write(REG_SETPOINT, 24'd6400);
		add_temp(0);
		add_temp(-1);
		add_temp(12800);

		wait (arst_n);
		@(posedge clk);
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_write)
				write_reg(row.reg_sel, row.data);
			else
				send_word(row.temp, row.typed, row.word);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if ($urandom_range(0, 1) == 1)
				write_reg(REG_SETPOINT, random_setpoint());
			if ($urandom_range(0, 1) == 1)
				write_reg(REG_GAIN_P, random_gain());
			if ($urandom_range(0, 1) == 1)
				write_reg(REG_GAIN_I, random_gain());
			if ($urandom_range(0, 1) == 1)
				write_reg(REG_GAIN_D, random_gain());
			calm = (ph == PHASES - 1);
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_word(random_temp(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (results_seen != words_sent)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_drive.size() != 0) begin
			$error("%0d drive words never arrived", expected_drive.size());
			fails++;
		end
		$display("sent %0d temperature samples across %0d register settings (%0d writes)",
			words_sent, PHASES + 1, writes_done);
		$display("compared %0d drive words, %0d field mismatches", results_seen, fails);
		if (fails == 0)
			$display("pid_heat_cool_drive_unit_tb passed");
		else
			$display("pid_heat_cool_drive_unit_tb failed");
		$finish;
	end

endmodule
